@@ design/sfr_pkg.sv @@
`default_nettype none

package sfr_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 16;
   localparam int FRAME_OVERHEAD      = 5;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;

   localparam logic [7:0] INCOMING_DATA_CODE_RST = 8'd1;
   localparam logic [7:0] REPROGRAM_CODE_RST     = 8'd3;

   // configuration register indexes
   localparam logic CSR_INCOMING_DATA_CODE = 1'b0;
   localparam logic CSR_REPROGRAM_CODE     = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUM   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_GOOD    = 2'd1,
      ST_BAD_SUM = 2'd2,
      ST_BAD_LEN = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] incoming_data_code;
      logic [7:0] reprogram_code;
   } cfg_type;

   typedef struct packed {
      logic        reprogram_request;
      logic [7:0]  output_bits;
      logic [15:0] voltage_setting;
      logic [7:0]  frame_command;
      status_type  frame_status;
   } result_type;

endpackage

`default_nettype wire

@@ design/sync_frame_receiver.sv @@
// Byte-serial frame receiver: hunts for 0x55 0xAA cmd len payload checksum frames and
// returns one result word per received byte (status, command, voltage and bits registers,
// reprogram pulse). Throughput is one byte per clock unless a low rsp_tready holds the result
// register; a byte is held in the input register, is parsed against the running frame state
// and lands in the result register, which raises rsp_tvalid. req_tready drops only while
// both registers are full and rsp_tready is low.
`default_nettype none

module sync_frame_receiver
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] frame_status, [9:2] frame_command, [25:10] voltage_setting,
   // [33:26] output_bits, [34] reprogram_request, [39:35] zero
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.incoming_data_code <= INCOMING_DATA_CODE_RST;
         cfg_ff.reprogram_code     <= REPROGRAM_CODE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INCOMING_DATA_CODE: cfg_ff.incoming_data_code <= csr_wr_data;
            CSR_REPROGRAM_CODE:     cfg_ff.reprogram_code     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
      if (advance) out_ff <= result;
   end

   sfr_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // reprogram pulse only on a good frame
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.reprogram_request |-> out_ff.frame_status == ST_GOOD)
      else $error("reprogram request without good frame");

   // no frame ended means no command reported
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_status == ST_NONE |-> out_ff.frame_command == 8'd0)
      else $error("command reported without frame end");

   // input stalls only when both stages are full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled without backpressure");

   // a stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_ff))
      else $error("held result changed");

endmodule

`default_nettype wire

@@ design/sfr_parser.sv @@
`default_nettype none

module sfr_parser
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam int         CNT_W   = $clog2(MAX_FRAME_BYTES);
   localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES - FRAME_OVERHEAD);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       head_ff [3];
   logic [7:0]       head_in [3];
   logic [15:0]      volt_ff, volt_in;
   logic [7:0]       bits_ff, bits_in;

   always_comb begin
      logic [7:0] sum_add;
      logic       resync;
      sum_add  = sum_ff + rx_byte;
      resync   = 1'b0;
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      head_in  = head_ff;
      volt_in  = volt_ff;
      bits_in  = bits_ff;
      result.frame_status      = ST_NONE;
      result.frame_command     = 8'd0;
      result.reprogram_request = 1'b0;

      case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) begin
               sum_in   = sum_add;
               phase_in = PH_CMD;
            end else begin
               resync = 1'b1;
            end
         end
         PH_CMD: begin
            cmd_in   = rx_byte;
            sum_in   = sum_add;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in = rx_byte;
            sum_in = sum_add;
            if (rx_byte > MAX_LEN) begin
               result.frame_status  = ST_BAD_LEN;
               result.frame_command = cmd_ff;
               resync               = 1'b1;
            end else begin
               count_in = '0;
               phase_in = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            if (count_ff == CNT_W'(0)) head_in[0] = rx_byte;
            if (count_ff == CNT_W'(1)) head_in[1] = rx_byte;
            if (count_ff == CNT_W'(2)) head_in[2] = rx_byte;
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_add;
            if (8'(count_ff) + 8'd1 >= len_ff) phase_in = PH_SUM;
         end
         PH_SUM: begin
            result.frame_command = cmd_ff;
            if (rx_byte == sum_ff) begin
               result.frame_status = ST_GOOD;
               if (cmd_ff == cfg.incoming_data_code) begin
                  volt_in = {head_ff[0], head_ff[1]};
                  bits_in = head_ff[2];
               end
               result.reprogram_request = (cmd_ff == cfg.reprogram_code);
            end else begin
               result.frame_status = ST_BAD_SUM;
            end
            resync = 1'b1;
         end
         default: begin
            if (rx_byte == SYNC_FIRST) begin
               head_in  = '{default: 8'd0};
               count_in = '0;
               sum_in   = rx_byte;
               phase_in = PH_SYNC2;
            end else begin
               resync = 1'b1;
            end
         end
      endcase

      if (resync) begin
         phase_in = PH_SYNC1;
         count_in = '0;
         sum_in   = 8'd0;
         cmd_in   = 8'd0;
         len_in   = 8'd0;
      end

      result.voltage_setting = volt_in;
      result.output_bits     = bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         count_ff <= '0;
         sum_ff   <= 8'd0;
         cmd_ff   <= 8'd0;
         len_ff   <= 8'd0;
         head_ff  <= '{default: 8'd0};
         volt_ff  <= 16'd0;
         bits_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         head_ff  <= head_in;
         volt_ff  <= volt_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_WAIT  = 4;
   localparam int MAX_PAYLOAD  = MAX_FRAME_BYTES_DEF - FRAME_OVERHEAD;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic        csr_index;
   logic [7:0]  csr_wr_data;

   // parser copy kept in step with every accepted byte
   logic [7:0]  data_code   = INCOMING_DATA_CODE_RST;
   logic [7:0]  reprog_code = REPROGRAM_CODE_RST;
   phase_type   parse_phase = PH_SYNC1;
   int          data_count  = 0;
   logic [7:0]  frame_sum   = '0;
   logic [7:0]  held_cmd    = '0;
   logic [7:0]  held_len    = '0;
   logic [7:0]  head_bytes[3] = '{default: 8'h00};
   logic [15:0] volt_reg    = '0;
   logic [7:0]  bits_reg    = '0;

   result_type  pending_results[$];
   logic [7:0]  payload_bytes[$];

   int          bytes_sent     = 0;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          send_gaps      = 1'b1;
   bit          recv_gaps      = 1'b1;
   bit          hold_rsp       = 1'b0;

   sync_frame_receiver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sync_frame_receiver verification failed");
         $finish;
      end
   end

   function automatic void note_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   function automatic void check_field(string name, int want_v, int got_v);
      if (want_v != got_v)
         note_error($sformatf("%s expected %0h got %0h", name, want_v, got_v));
   endfunction

   function automatic void drop_frame();
      parse_phase = PH_SYNC1;
      data_count  = 0;
      frame_sum   = '0;
      held_cmd    = '0;
      held_len    = '0;
   endfunction

   // advance the parser copy by one byte and queue the word it must produce
   function automatic void frame_predict(logic [7:0] b);
      result_type r;
      r = '0;
      case (parse_phase)
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               frame_sum += b;
               parse_phase = PH_CMD;
            end else begin
               drop_frame();
            end
         end
         PH_CMD: begin
            held_cmd = b;
            frame_sum += b;
            parse_phase = PH_LEN;
         end
         PH_LEN: begin
            held_len = b;
            frame_sum += b;
            if (int'(b) > MAX_PAYLOAD) begin
               r.frame_status  = ST_BAD_LEN;
               r.frame_command = held_cmd;
               drop_frame();
            end else begin
               data_count  = 0;
               parse_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            if (data_count < 3)
               head_bytes[data_count] = b;
            data_count++;
            frame_sum += b;
            if (data_count >= int'(held_len))
               parse_phase = PH_SUM;
         end
         PH_SUM: begin
            r.frame_command = held_cmd;
            if (b == frame_sum) begin
               r.frame_status = ST_GOOD;
               if (held_cmd == data_code) begin
                  volt_reg = {head_bytes[0], head_bytes[1]};
                  bits_reg = head_bytes[2];
               end
               r.reprogram_request = (held_cmd == reprog_code);
            end else begin
               r.frame_status = ST_BAD_SUM;
            end
            drop_frame();
         end
         default: begin
            if (b == SYNC_FIRST) begin
               head_bytes  = '{default: 8'h00};
               data_count  = 0;
               frame_sum   = b;
               parse_phase = PH_SYNC2;
            end else begin
               drop_frame();
            end
         end
      endcase
      r.voltage_setting = volt_reg;
      r.output_bits     = bits_reg;
      pending_results.push_back(r);
   endfunction

   // result side: random stalls per word, plus one long hold on request
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++)
               @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = recv_gaps ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            check_field("frame_status", int'(want.frame_status), int'(got.frame_status));
            check_field("frame_command", want.frame_command, got.frame_command);
            check_field("voltage_setting", want.voltage_setting, got.voltage_setting);
            check_field("output_bits", want.output_bits, got.output_bits);
            check_field("reprogram_request", want.reprogram_request, got.reprogram_request);
         end
      end
   end

   // entered and left at a falling edge; valid stays high across back-to-back words
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = send_gaps ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      frame_predict(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // payload comes from payload_bytes, padded with random bytes when short
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = SYNC_FIRST + SYNC_SECOND + cmd + len;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(cmd);
      send_byte(len);
      if (int'(len) <= MAX_PAYLOAD) begin
         for (int i = 0; i < int'(len); i++) begin
            b = (payload_bytes.size() != 0) ? payload_bytes.pop_front() : 8'($urandom);
            sum += b;
            send_byte(b);
         end
         send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
      end
      payload_bytes.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_INCOMING_DATA_CODE)
         data_code = value;
      else
         reprog_code = value;
      @(negedge clock);
   endtask

   task automatic test_frame_kinds();
      payload_bytes = '{8'hFF, 8'h00, 8'hFF};
      send_frame(data_code, 8'd3, 1'b0);
      send_frame(reprog_code, 8'd0, 1'b0);
      send_frame(data_code, 8'd2, 1'b1);
      send_frame(8'h7E, 8'(MAX_PAYLOAD + 1), 1'b0);
      // second sync wrong: must fall back to hunting
      send_byte(SYNC_FIRST);
      send_byte(8'h12);
   endtask

   task automatic test_config_sweep();
      logic [7:0] data_set[5];
      logic [7:0] reprog_set[5];
      data_set   = '{8'h00, 8'hFF, 8'h2A, 8'h55, INCOMING_DATA_CODE_RST};
      reprog_set = '{8'hFF, 8'h00, 8'h2A, 8'hAA, REPROGRAM_CODE_RST};
      for (int k = 0; k < 5; k++) begin
         wait_idle();
         write_csr(CSR_INCOMING_DATA_CODE, data_set[k]);
         write_csr(CSR_REPROGRAM_CODE, reprog_set[k]);
         send_frame(data_code, 8'd3, 1'b0);
         // one byte only: the other two read as zero
         send_frame(data_code, 8'd1, 1'b0);
         send_frame(reprog_code, 8'd0, 1'b0);
         send_frame(8'($urandom), 8'(MAX_PAYLOAD), 1'b0);
         send_frame(data_code, 8'd0, 1'b0);
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_rsp  = 1'b1;
      send_gaps = 1'b0;
      repeat (4) send_frame(data_code, 8'd3, 1'b0);
      wait_idle();
      send_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      int start_count;
      int next_cfg;
      int pick;
      logic [7:0] cmd;
      logic [7:0] len;
      start_count = bytes_sent;
      next_cfg    = bytes_sent + 150;
      while (bytes_sent - start_count < 500) begin
         if ($urandom_range(0, 7) == 0) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
         end
         if (bytes_sent >= next_cfg) begin
            wait_idle();
            write_csr(CSR_INCOMING_DATA_CODE, 8'($urandom));
            write_csr(CSR_REPROGRAM_CODE,
                      ($urandom_range(0, 3) == 0) ? data_code : 8'($urandom));
            next_cfg = bytes_sent + 150;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            case ($urandom_range(0, 2))
               0: cmd = data_code;
               1: cmd = reprog_code;
               default: cmd = 8'($urandom);
            endcase
            len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(MAX_PAYLOAD + 1, 255))
                                               : 8'($urandom_range(0, MAX_PAYLOAD));
            send_frame(cmd, len, $urandom_range(0, 9) == 0);
         end else if (pick < 88) begin
            // header cut short
            send_byte(SYNC_FIRST);
            send_byte($urandom_range(0, 1) ? SYNC_SECOND : 8'($urandom));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
         end
      end
   endtask

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_frame_kinds();
      test_config_sweep();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0)
         $display("sync_frame_receiver verification clean");
      else
         $display("sync_frame_receiver verification failed");
      $finish;
   end

endmodule

`default_nettype wire
